@@ hdl/three_stacks_in_one_memory_macros.svh @@
`ifndef THREE_STACKS_IN_ONE_MEMORY_MACROS_SVH
`define THREE_STACKS_IN_ONE_MEMORY_MACROS_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define TSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define TSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tsm_pkg.sv @@
`timescale 1ns / 1ps

package tsm_pkg;

    // Number of stacks that share the memory.
    localparam int NUM_STACKS = 3;

    // Default sizing of the block.
    localparam int DEF_MAX_PER_STACK = 256;
    localparam int DEF_DATA_WIDTH    = 32;

    // Field widths of the item and of the capacity register.
    localparam int CMD_W = 2;
    localparam int STK_W = 2;
    localparam int CFG_W = 9;

    // Capacity after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_EMPTY = 2'd3
    } t_cmd;

endpackage

@@ hdl/tsm_ram.sv @@
`timescale 1ns / 1ps

module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/three_stacks_in_one_memory.sv @@
// The result of an accepted item passes through stage one and then the output register.
// Throughput: one item per cycle while results are taken; each item makes at most one
// access to the one port of the shared stack memory, and fill counts update at the accept edge.
// Reset (synchronous, active low) empties all three stacks, sets the capacity
// to 256 and clears the pipeline; the stack memory itself is not cleared.
`timescale 1ns / 1ps

`include "three_stacks_in_one_memory_macros.svh"

module three_stacks_in_one_memory
    import tsm_pkg::*;
#(
    parameter int MAX_PER_STACK = DEF_MAX_PER_STACK,
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input item channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [STK_W-1:0]      i_stack_num,
    input  logic [DATA_WIDTH-1:0] i_push_value,
    // Result item channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_WIDTH-1:0] o_read_value,
    output logic                  o_stack_empty,
    output logic                  o_push_dropped,
    // Capacity register.
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int DEPTH  = NUM_STACKS * MAX_PER_STACK;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_PER_STACK + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Control state.
    logic [CFG_W-1:0]      r_stack_size;
    logic [CNT_W-1:0]      r_fill [NUM_STACKS];
    logic                  r_s1_valid;
    logic                  r_s1_rd;
    logic                  r_s1_empty;
    logic                  r_s1_dropped;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_empty;
    logic                  r_out_dropped;

    // Decode of the incoming item.
    logic                  in_acc;
    logic                  s1_move;
    logic                  stk_ok;
    logic [CNT_W-1:0]      fill_sel;
    logic [CMP_W-1:0]      cap;
    logic                  is_empty;
    logic                  push_ok;
    logic                  push_drop;
    logic                  do_read;
    logic                  do_pop;
    logic [CNT_W-1:0]      idx;
    logic [ADDR_W-1:0]     mem_addr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Handshake: stage one advances when the output register is free or drains.
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    // Fill count and capacity of the addressed stack.
    assign stk_ok   = i_stack_num < STK_W'(NUM_STACKS);
    assign fill_sel = stk_ok ? r_fill[i_stack_num] : '0;
    assign cap      = (CMP_W'(r_stack_size) > CMP_W'(MAX_PER_STACK))
                      ? CMP_W'(MAX_PER_STACK) : CMP_W'(r_stack_size);
    assign is_empty = (fill_sel == '0);

    // Command outcome.
    always_comb begin
        push_ok   = 1'b0;
        push_drop = 1'b0;
        do_read   = 1'b0;
        do_pop    = 1'b0;
        case (t_cmd'(i_command))
            CMD_PUSH: begin
                push_ok   = stk_ok && (CMP_W'(fill_sel) < cap);
                push_drop = !push_ok;
            end
            CMD_POP: begin
                do_read = stk_ok && !is_empty;
                do_pop  = stk_ok && !is_empty;
            end
            CMD_PEEK: begin
                do_read = stk_ok && !is_empty;
            end
            default: begin
            end
        endcase
    end

    // Word address inside the partition of the addressed stack.
    assign idx      = push_ok ? fill_sel : fill_sel - 1'b1;
    assign mem_addr = ADDR_W'(i_stack_num) * ADDR_W'(MAX_PER_STACK) + ADDR_W'(idx);

    tsm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && push_ok),
        .i_re    (in_acc && do_read),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_size <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_stack_size <= i_cfg_data;
        end
    end

    // Fill counts change at the accept edge, so the next item sees them at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_fill[k] <= '0;
            end
        end else if (in_acc && push_ok) begin
            r_fill[i_stack_num] <= fill_sel + 1'b1;
        end else if (in_acc && do_pop) begin
            r_fill[i_stack_num] <= fill_sel - 1'b1;
        end
    end

    // Stage one waits for the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rd      <= do_read;
            r_s1_empty   <= is_empty;
            r_s1_dropped <= push_drop;
        end
    end

    // Output register holds the result item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value   <= r_s1_rd ? mem_rdata : '1;
            r_out_empty   <= r_s1_empty;
            r_out_dropped <= r_s1_dropped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_stack_empty  = r_out_empty;
    assign o_push_dropped = r_out_dropped;

    // Checks on the pipeline and the fill counts.
    `TSM_ASSERT_NEXT(a_acc_fills_s1, in_acc, r_s1_valid, "accepted item did not reach stage one")
    `TSM_ASSERT_NOW(a_stall_blocks, r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready, "item accepted while stage one is blocked")
    `TSM_ASSERT_NOW(a_drop_no_read, r_s1_valid && r_s1_dropped, !r_s1_rd, "dropped push marked as a read")
    `TSM_ASSERT_NEXT(a_push_counts, in_acc && push_ok && (i_stack_num == '0), r_fill[0] == $past(r_fill[0]) + 1'b1, "push did not advance the fill count")

endmodule
